FILE: sv/dtqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtqs_pkg: shared types and constants for the deferred task queue scheduler
// operation codes, status codes and default store depths
// ----------------------------------------------------------------------------
package dtqs_pkg;

  localparam int READY_DEPTH_DEF    = 16;
  localparam int DEFERRED_DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    OP_PUSH_READY = 3'd0,
    OP_PUSH_DEFER = 3'd1,
    OP_POP        = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_TICK       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

FILE: sv/dtqs_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtqs_match: shared compare unit
// 32-bit id equality and elapsed-tick due test for one entry per cycle
// ----------------------------------------------------------------------------
module dtqs_match (
  input  logic [31:0] id_a,
  input  logic [31:0] id_b,
  input  logic [31:0] tick_now,
  input  logic [31:0] stamp,
  input  logic [19:0] delay,
  output logic        id_eq,
  output logic        due
);
  logic [31:0] elapsed;
  assign id_eq   = (id_a == id_b);
  assign elapsed = tick_now - stamp;
  assign due     = (elapsed >= {12'd0, delay});
endmodule

FILE: sv/deferred_task_queue_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deferred_task_queue_scheduler: ready fifo plus deferred list with promotion
// sequencer walks entries one per cycle through a shared compare unit
// ----------------------------------------------------------------------------
// Push and tick pass through S_EXEC and S_DONE while busy is high. Pop scans the
// deferred list, then takes the ready fifo head and closes up the fifo. On each
// promotion the entry moves, the list closes up one entry per cycle and the scan
// restarts at the head. Remove compares the ready entry and then the deferred
// entry at each position, one compare per cycle, and on a match closes up that
// store. The result word is on the out_ ports with out_valid for one cycle,
// right after busy falls; the receiver cannot stall it.
module deferred_task_queue_scheduler #(
  parameter int READY_DEPTH    = dtqs_pkg::READY_DEPTH_DEF,
  parameter int DEFERRED_DEPTH = dtqs_pkg::DEFERRED_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_task_handle,
  input  logic [19:0] in_delay_ticks,
  input  logic        in_express,
  input  logic [31:0] in_target_id,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_assigned_id,
  output logic [31:0] out_popped_handle
);
  localparam int RW = $clog2(READY_DEPTH);
  localparam int DW = $clog2(DEFERRED_DEPTH);
  localparam int RC = $clog2(READY_DEPTH + 1);
  localparam int DC = $clog2(DEFERRED_DEPTH + 1);
  localparam int MW = (RC > DC) ? RC : DC;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_EXEC  = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_DSHFT = 8'b00001000,
    S_RSHFT = 8'b00010000,
    S_SRCH  = 8'b00100000,
    S_POPF  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  logic [31:0] r_ids [READY_DEPTH];
  logic [31:0] r_hnd [READY_DEPTH];
  logic [31:0] d_ids [DEFERRED_DEPTH];
  logic [31:0] d_hnd [DEFERRED_DEPTH];
  logic        d_exp [DEFERRED_DEPTH];
  logic [19:0] d_dly [DEFERRED_DEPTH];
  logic [31:0] d_stp [DEFERRED_DEPTH];

  state_t      state_r;
  logic [RC-1:0] rcnt_r;
  logic [DC-1:0] dcnt_r;
  logic [31:0] next_id_r, tick_r;
  logic [MW-1:0] k_r;
  logic        pop_mode_r; // remove vs pop after shift
  logic        side_r;     // search: ready entry first, then deferred entry
  logic [2:0]  op_r;
  logic [31:0] hnd_in_r, tgt_r;
  logic [19:0] dly_in_r;
  logic        exp_in_r;
  logic [1:0]  st_r;
  logic [31:0] aid_r, ph_r;
  logic        ov_r;

  logic [DW-1:0] dk;
  logic [RW-1:0] rk;
  logic [31:0]   cmp_id;
  logic          id_eq, due;
  logic          k_in_r, k_in_d, k_end;

  assign dk = k_r[DW-1:0];
  assign rk = k_r[RW-1:0];
  assign k_in_r = ({{(MW-RC){1'b0}}, rcnt_r} > k_r) && (k_r < MW'(READY_DEPTH));
  assign k_in_d = ({{(MW-DC){1'b0}}, dcnt_r} > k_r) && (k_r < MW'(DEFERRED_DEPTH));
  assign cmp_id = side_r ? d_ids[dk] : r_ids[rk];

  dtqs_match u_cmp (.id_a(cmp_id), .id_b(tgt_r), .tick_now(tick_r),
    .stamp(d_stp[dk]), .delay(d_dly[dk]), .id_eq(id_eq), .due(due));

  assign k_end = !k_in_r && !k_in_d;

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_assigned_id = aid_r;
  assign out_popped_handle = ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; rcnt_r <= '0; dcnt_r <= '0;
      next_id_r <= '0; tick_r <= '0; ov_r <= 1'b0;
    end else begin
      ov_r <= (state_r == S_DONE);
      case (state_r)
        S_IDLE: if (start) begin
          op_r <= in_operation; hnd_in_r <= in_task_handle;
          dly_in_r <= in_delay_ticks; exp_in_r <= in_express; tgt_r <= in_target_id;
          st_r <= dtqs_pkg::ST_OK; aid_r <= '0; ph_r <= '0; k_r <= '0;
          side_r <= 1'b0;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_DONE;
          case (op_r)
            dtqs_pkg::OP_PUSH_READY: begin
              if (rcnt_r >= RC'(READY_DEPTH)) st_r <= dtqs_pkg::ST_FULL;
              else begin
                r_ids[rcnt_r[RW-1:0]] <= next_id_r;
                r_hnd[rcnt_r[RW-1:0]] <= hnd_in_r;
                rcnt_r <= rcnt_r + 1'b1; aid_r <= next_id_r;
                next_id_r <= next_id_r + 1'b1;
              end
            end
            dtqs_pkg::OP_PUSH_DEFER: begin
              if (dcnt_r >= DC'(DEFERRED_DEPTH)) st_r <= dtqs_pkg::ST_FULL;
              else begin
                d_ids[dcnt_r[DW-1:0]] <= next_id_r;
                d_hnd[dcnt_r[DW-1:0]] <= hnd_in_r;
                d_exp[dcnt_r[DW-1:0]] <= exp_in_r;
                d_dly[dcnt_r[DW-1:0]] <= dly_in_r;
                d_stp[dcnt_r[DW-1:0]] <= tick_r;
                dcnt_r <= dcnt_r + 1'b1; aid_r <= next_id_r;
                next_id_r <= next_id_r + 1'b1;
              end
            end
            dtqs_pkg::OP_POP: state_r <= S_SCAN;
            dtqs_pkg::OP_REMOVE: begin
              st_r <= dtqs_pkg::ST_EMPTY; state_r <= S_SRCH;
            end
            dtqs_pkg::OP_TICK: tick_r <= tick_r + 1'b1;
            default: ;
          endcase
        end
        S_SCAN: begin
          if (!k_in_d) begin
            state_r <= S_POPF;
          end else if (((rcnt_r == '0) && d_exp[dk] || due) &&
                       rcnt_r < RC'(READY_DEPTH)) begin
            r_ids[rcnt_r[RW-1:0]] <= d_ids[dk];
            r_hnd[rcnt_r[RW-1:0]] <= d_hnd[dk];
            rcnt_r <= rcnt_r + 1'b1;
            pop_mode_r <= 1'b1;
            state_r <= S_DSHFT;
          end else k_r <= k_r + 1'b1;
        end
        S_POPF: begin
          if (rcnt_r == '0) begin
            st_r <= dtqs_pkg::ST_EMPTY; state_r <= S_DONE;
          end else begin
            ph_r <= r_hnd[0]; k_r <= '0; pop_mode_r <= 1'b0;
            state_r <= S_RSHFT;
          end
        end
        S_SRCH: begin
          if (k_end) state_r <= S_DONE;
          else if (!side_r) begin
            if (k_in_r && id_eq) begin
              st_r <= dtqs_pkg::ST_OK; pop_mode_r <= 1'b0; state_r <= S_RSHFT;
            end else side_r <= 1'b1;
          end else begin
            if (k_in_d && id_eq) begin
              st_r <= dtqs_pkg::ST_OK; pop_mode_r <= 1'b0; state_r <= S_DSHFT;
            end else begin
              side_r <= 1'b0; k_r <= k_r + 1'b1;
            end
          end
        end
        S_DSHFT: begin
          // close the gap one entry per cycle
          if (k_r + 1'b1 < {{(MW-DC){1'b0}}, dcnt_r} &&
              k_r + 1'b1 < MW'(DEFERRED_DEPTH)) begin
            d_ids[dk] <= d_ids[DW'(k_r + 1'b1)];
            d_hnd[dk] <= d_hnd[DW'(k_r + 1'b1)];
            d_exp[dk] <= d_exp[DW'(k_r + 1'b1)];
            d_dly[dk] <= d_dly[DW'(k_r + 1'b1)];
            d_stp[dk] <= d_stp[DW'(k_r + 1'b1)];
            k_r <= k_r + 1'b1;
          end else begin
            dcnt_r <= dcnt_r - 1'b1;
            if (pop_mode_r) begin
              k_r <= '0; state_r <= S_SCAN; // rescan from start: order kept
            end else state_r <= S_DONE;
          end
        end
        S_RSHFT: begin
          if (k_r + 1'b1 < {{(MW-RC){1'b0}}, rcnt_r} &&
              k_r + 1'b1 < MW'(READY_DEPTH)) begin
            r_ids[rk] <= r_ids[RW'(k_r + 1'b1)];
            r_hnd[rk] <= r_hnd[RW'(k_r + 1'b1)];
            k_r <= k_r + 1'b1;
          end else begin
            rcnt_r <= rcnt_r - 1'b1; state_r <= S_DONE;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/dtqs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtqs_checker: port-level checks for the deferred task queue scheduler
// result strobe, busy framing and status encoding
// ----------------------------------------------------------------------------
module dtqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_assigned_id,
  input logic [31:0] out_popped_handle
);
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy with result word");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_full_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != dtqs_pkg::ST_OK) |-> out_assigned_id == 32'd0 &&
    out_popped_handle == 32'd0) else $error("nonzero fields on failure");
endmodule

bind deferred_task_queue_scheduler dtqs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_assigned_id(out_assigned_id),
  .out_popped_handle(out_popped_handle)
);

FILE: tb/deferred_task_queue_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deferred_task_queue_scheduler_tb: self-checking bench for the task scheduler
// drives a directed table, store fills and random command words, predicts every result
// word with a behavioral copy of both stores and compares field by field
// ----------------------------------------------------------------------------
module deferred_task_queue_scheduler_tb;

  localparam int RD = dtqs_pkg::READY_DEPTH_DEF;
  localparam int DD = dtqs_pkg::DEFERRED_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] task_handle;
    logic [19:0] delay_ticks;
    logic        express;
    logic [31:0] target_id;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic [31:0] popped_handle;
  } rsp_word_t;

  typedef struct {
    cmd_word_t cmd;
    logic      fixed;
    rsp_word_t rsp;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_operation;
  logic [31:0] in_task_handle;
  logic [19:0] in_delay_ticks;
  logic        in_express;
  logic [31:0] in_target_id;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_assigned_id;
  logic [31:0] out_popped_handle;

  // scheduler image
  logic [31:0] rdy_id [RD];
  logic [31:0] rdy_hdl [RD];
  int          rdy_n;
  logic [31:0] dfr_id [DD];
  logic [31:0] dfr_hdl [DD];
  logic        dfr_exp [DD];
  logic [19:0] dfr_dly [DD];
  logic [31:0] dfr_stamp [DD];
  int          dfr_n;
  logic [31:0] id_next;
  logic [31:0] now_ticks;

  rsp_word_t   pending_rsp[$];
  int          fail_cnt;
  int          idle_cycles;
  table_row_t  dir_rows[$];

  deferred_task_queue_scheduler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_task_handle   (in_task_handle),
    .in_delay_ticks   (in_delay_ticks),
    .in_express       (in_express),
    .in_target_id     (in_target_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_assigned_id  (out_assigned_id),
    .out_popped_handle(out_popped_handle)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic drop_ready(input int pos);
    for (int k = pos; k + 1 < rdy_n; k++) begin
      rdy_id[k]  = rdy_id[k + 1];
      rdy_hdl[k] = rdy_hdl[k + 1];
    end
    rdy_n--;
  endtask

  task automatic drop_deferred(input int pos);
    for (int k = pos; k + 1 < dfr_n; k++) begin
      dfr_id[k]    = dfr_id[k + 1];
      dfr_hdl[k]   = dfr_hdl[k + 1];
      dfr_exp[k]   = dfr_exp[k + 1];
      dfr_dly[k]   = dfr_dly[k + 1];
      dfr_stamp[k] = dfr_stamp[k + 1];
    end
    dfr_n--;
  endtask

  task automatic schedule_cmd(input cmd_word_t c, output rsp_word_t r);
    int          k;
    logic        jump;
    logic [31:0] elapsed;
    r = '0;
    case (c.operation)
      dtqs_pkg::OP_PUSH_READY: begin
        if (rdy_n >= RD) r.status = dtqs_pkg::ST_FULL;
        else begin
          rdy_id[rdy_n]  = id_next;
          rdy_hdl[rdy_n] = c.task_handle;
          rdy_n++;
          r.assigned_id = id_next;
          id_next++;
        end
      end
      dtqs_pkg::OP_PUSH_DEFER: begin
        if (dfr_n >= DD) r.status = dtqs_pkg::ST_FULL;
        else begin
          dfr_id[dfr_n]    = id_next;
          dfr_hdl[dfr_n]   = c.task_handle;
          dfr_exp[dfr_n]   = c.express;
          dfr_dly[dfr_n]   = c.delay_ticks;
          dfr_stamp[dfr_n] = now_ticks;
          dfr_n++;
          r.assigned_id = id_next;
          id_next++;
        end
      end
      dtqs_pkg::OP_POP: begin
        k = 0;
        while (k < dfr_n) begin
          jump    = (rdy_n == 0) && dfr_exp[k];
          elapsed = now_ticks - dfr_stamp[k];
          if ((jump || elapsed >= {12'd0, dfr_dly[k]}) && rdy_n < RD) begin
            rdy_id[rdy_n]  = dfr_id[k];
            rdy_hdl[rdy_n] = dfr_hdl[k];
            rdy_n++;
            drop_deferred(k);
          end else k++;
        end
        if (rdy_n == 0) r.status = dtqs_pkg::ST_EMPTY;
        else begin
          r.popped_handle = rdy_hdl[0];
          drop_ready(0);
        end
      end
      dtqs_pkg::OP_REMOVE: begin
        r.status = dtqs_pkg::ST_EMPTY;
        for (k = 0; k < RD || k < DD; k++) begin
          if (k < rdy_n && rdy_id[k] == c.target_id) begin
            drop_ready(k);
            r.status = dtqs_pkg::ST_OK;
            break;
          end
          if (k < dfr_n && dfr_id[k] == c.target_id) begin
            drop_deferred(k);
            r.status = dtqs_pkg::ST_OK;
            break;
          end
        end
      end
      dtqs_pkg::OP_TICK: now_ticks++;
      default: ;
    endcase
  endtask

  // result side: every strobe must match the oldest expectation
  always @(posedge clk) begin
    rsp_word_t e;
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result word status=%0d", out_status);
        fail_cnt++;
      end else begin
        e = pending_rsp[0];
        pending_rsp.delete(0);
        if (out_status !== e.status) begin
          $error("status exp=%0d act=%0d", e.status, out_status);
          fail_cnt++;
        end
        if (out_assigned_id !== e.assigned_id) begin
          $error("assigned_id exp=%h act=%h", e.assigned_id, out_assigned_id);
          fail_cnt++;
        end
        if (out_popped_handle !== e.popped_handle) begin
          $error("popped_handle exp=%h act=%h", e.popped_handle, out_popped_handle);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // start stays high between back-to-back words; busy blocks a second accept
  task automatic send_cmd(input cmd_word_t c, input logic fixed, input rsp_word_t fr);
    rsp_word_t p;
    int        gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    schedule_cmd(c, p);
    if (fixed && p !== fr) begin
      $error("table row disagrees with scheduler image: row=%h image=%h", fr, p);
      fail_cnt++;
    end
    pending_rsp = {pending_rsp, p};
    start          <= 1'b1;
    in_operation   <= c.operation;
    in_task_handle <= c.task_handle;
    in_delay_ticks <= c.delay_ticks;
    in_express     <= c.express;
    in_target_id   <= c.target_id;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic cmd_word_t mk(input logic [2:0] op, input logic [31:0] h,
                                   input logic [19:0] d, input logic x,
                                   input logic [31:0] t);
    cmd_word_t c;
    c.operation = op; c.task_handle = h; c.delay_ticks = d;
    c.express = x; c.target_id = t;
    return c;
  endfunction

  function automatic rsp_word_t rs(input logic [1:0] s, input logic [31:0] a,
                                   input logic [31:0] p);
    rsp_word_t r;
    r.status = s; r.assigned_id = a; r.popped_handle = p;
    return r;
  endfunction

  task automatic add_row(input cmd_word_t c, input logic fixed, input rsp_word_t r);
    table_row_t t;
    t.cmd = c; t.fixed = fixed; t.rsp = r;
    dir_rows = {dir_rows, t};
  endtask

  task automatic drain_wait();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  function automatic cmd_word_t rand_cmd();
    cmd_word_t c;
    int        sel;
    logic [31:0] tgt;
    sel = $urandom_range(0, 99);
    c = mk(dtqs_pkg::OP_TICK, $urandom, 20'($urandom), 1'($urandom), $urandom);
    if (sel < 22) c.operation = dtqs_pkg::OP_PUSH_READY;
    else if (sel < 44) c.operation = dtqs_pkg::OP_PUSH_DEFER;
    else if (sel < 70) c.operation = dtqs_pkg::OP_POP;
    else if (sel < 82) c.operation = dtqs_pkg::OP_REMOVE;
    else if (sel < 97) c.operation = dtqs_pkg::OP_TICK;
    else c.operation = 3'($urandom_range(5, 7));
    // mostly short delays so promotion happens, sometimes huge ones
    if ($urandom_range(0, 9) != 0) c.delay_ticks = 20'($urandom_range(0, 6));
    if (c.operation == dtqs_pkg::OP_REMOVE && $urandom_range(0, 3) != 0) begin
      tgt = id_next - 32'($urandom_range(1, 40));
      c.target_id = tgt;
    end
    return c;
  endfunction

  initial begin
    rsp_word_t z;
    z = '0;
    fail_cnt = 0;
    rdy_n = 0; dfr_n = 0; id_next = '0; now_ticks = '0;
    rst_n = 1'b0; start = 1'b0;
    in_operation = '0; in_task_handle = '0; in_delay_ticks = '0;
    in_express = 1'b0; in_target_id = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table: empty cases, extremes, unused codes, express jump
    add_row(mk(dtqs_pkg::OP_POP, '1, '1, 1'b1, '1), 1'b1,
            rs(dtqs_pkg::ST_EMPTY, 32'd0, 32'd0));
    add_row(mk(dtqs_pkg::OP_REMOVE, '1, '1, 1'b1, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_EMPTY, 32'd0, 32'd0));
    add_row(mk(3'd5, '1, '1, 1'b1, '1), 1'b1, rs(dtqs_pkg::ST_OK, 32'd0, 32'd0));
    add_row(mk(3'd7, '1, '1, 1'b1, '1), 1'b1, rs(dtqs_pkg::ST_OK, 32'd0, 32'd0));
    add_row(mk(dtqs_pkg::OP_PUSH_READY, 32'hFFFF_FFFF, 20'd0, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd0, 32'd0));
    add_row(mk(dtqs_pkg::OP_PUSH_DEFER, 32'h0, 20'hFFFFF, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd1, 32'd0));
    add_row(mk(dtqs_pkg::OP_PUSH_DEFER, 32'hA5A5_5A5A, 20'hFFFFF, 1'b1, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd2, 32'd0));
    add_row(mk(dtqs_pkg::OP_POP, 32'd0, 20'd0, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd0, 32'hFFFF_FFFF));
    add_row(mk(dtqs_pkg::OP_POP, 32'd0, 20'd0, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd0, 32'hA5A5_5A5A));
    add_row(mk(dtqs_pkg::OP_POP, 32'd0, 20'd0, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_EMPTY, 32'd0, 32'd0));
    add_row(mk(dtqs_pkg::OP_REMOVE, 32'd0, 20'd0, 1'b0, 32'd1), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd0, 32'd0));
    add_row(mk(dtqs_pkg::OP_PUSH_DEFER, 32'h1234, 20'd2, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd3, 32'd0));
    add_row(mk(dtqs_pkg::OP_TICK, 32'd0, 20'd0, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd0, 32'd0));
    add_row(mk(dtqs_pkg::OP_POP, 32'd0, 20'd0, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_EMPTY, 32'd0, 32'd0));
    add_row(mk(dtqs_pkg::OP_TICK, 32'd0, 20'd0, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd0, 32'd0));
    add_row(mk(dtqs_pkg::OP_POP, 32'd0, 20'd0, 1'b0, 32'd0), 1'b1,
            rs(dtqs_pkg::ST_OK, 32'd0, 32'h1234));
    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].rsp);
    // fill both stores past capacity, then promote into a full fifo
    for (int i = 0; i < RD + 1; i++)
      send_cmd(mk(dtqs_pkg::OP_PUSH_READY, $urandom, 20'd0, 1'b0, 32'd0), 1'b0, z);
    for (int i = 0; i < DD + 1; i++)
      send_cmd(mk(dtqs_pkg::OP_PUSH_DEFER, $urandom, 20'd0, 1'($urandom), 32'd0),
               1'b0, z);
    for (int i = 0; i < RD + DD + 1; i++)
      send_cmd(mk(dtqs_pkg::OP_POP, 32'd0, 20'd0, 1'b0, 32'd0), 1'b0, z);

    drain_wait();

    for (int i = 0; i < 820; i++) begin
      send_cmd(rand_cmd(), 1'b0, z);
      if (i == 410) drain_wait();
    end

    drain_wait();
    repeat (100) @(negedge clk);
    if (fail_cnt == 0 && pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
